@@ rtl/tile_gid_decoder_assert.svh @@
// Assertion macros for the tile decoder top level.
// Define ASSERT_OFF to compile all checks away.
`ifndef TILE_GID_DECODER_ASSERT_SVH
`define TILE_GID_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define TGD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tile decoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tile decoder assertion failed");

`else

`define TGD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TGD_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/tgd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tgd_pkg;

  // Pixel size of one square tile.
  localparam int unsigned TILE_SIZE = 32;

  // Field widths.
  localparam int unsigned GID_W      = 32;
  localparam int unsigned ID_W       = 28;
  localparam int unsigned COLS_W     = 11;
  localparam int unsigned MAPW_W     = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned SRC_X_W    = 15;
  localparam int unsigned SRC_Y_W    = 33;
  localparam int unsigned DST_W      = 17;
  localparam int unsigned CNT_W      = $clog2(ID_W);
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  // Flag bit positions in the raw tile word.
  localparam int unsigned FLAG_H_BIT = 31;
  localparam int unsigned FLAG_V_BIT = 30;
  localparam int unsigned FLAG_D_BIT = 29;

  // Register limits.
  localparam logic [COLS_W-1:0] COLS_MAX = COLS_W'(1024);
  localparam logic [MAPW_W-1:0] MAPW_MAX = MAPW_W'(4096);
  localparam logic [POS_W-1:0]  ROW_MAX  = POS_W'(4095);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TILESET_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH       = 1'b1;

  // Queue between front and back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [GID_W-1:0] raw_gid;
    logic             last_in_layer;
  } in_beat_t;

  typedef struct packed {
    logic [SRC_X_W-1:0] src_x_px;
    logic [SRC_Y_W-1:0] src_y_px;
    logic               flip_h;
    logic               flip_v;
    logic [DST_W-1:0]   dst_x_px;
    logic [DST_W-1:0]   dst_y_px;
    logic               empty_cell;
  } out_beat_t;

  // Classified cell waiting for its divide.
  typedef struct packed {
    logic [ID_W-1:0]  index;
    logic             empty_cell;
    logic             flip_h;
    logic             flip_v;
    logic [DST_W-1:0] dst_x_px;
    logic [DST_W-1:0] dst_y_px;
  } cell_t;

endpackage

`default_nettype wire

@@ rtl/tgd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tgd_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire tgd_pkg::in_beat_t             in_data_i,
  input  wire logic [tgd_pkg::MAPW_W-1:0]    map_width_i,
  output logic                               push_o,
  output tgd_pkg::cell_t                     push_data_o,
  input  wire logic                          q_full_i
);
  import tgd_pkg::*;

  logic [POS_W-1:0]  col_q, col_d;
  logic [POS_W-1:0]  row_q, row_d;
  logic [ID_W-1:0]   id;
  logic              empty;
  logic              fh, fv;
  logic              h, v, d;
  logic [MAPW_W-1:0] next_col;
  logic              accept;

  // A beat is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  // Split the word into flags and tile id.
  assign h     = in_data_i.raw_gid[FLAG_H_BIT];
  assign v     = in_data_i.raw_gid[FLAG_V_BIT];
  assign d     = in_data_i.raw_gid[FLAG_D_BIT];
  assign id    = in_data_i.raw_gid[ID_W-1:0];
  assign empty = (id == '0);

  // On a non-empty cell both flags together always flip; a single flag only without diagonal.
  assign fh = !empty && h && (v || !d);
  assign fv = !empty && v && (h || !d);

  always_comb begin
    push_data_o.index      = empty ? '0 : id - ID_W'(1);
    push_data_o.empty_cell = empty;
    push_data_o.flip_h     = fh;
    push_data_o.flip_v     = fv;
    push_data_o.dst_x_px   = DST_W'(32'(col_q) * 32'(TILE_SIZE));
    push_data_o.dst_y_px   = DST_W'(32'(row_q) * 32'(TILE_SIZE));
  end

  // Position advances per cell, wraps at map width, row saturates; last_in_layer clears it.
  assign next_col = MAPW_W'(col_q) + MAPW_W'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (in_data_i.last_in_layer) begin
        col_d = '0;
        row_d = '0;
      end else if (next_col >= map_width_i) begin
        col_d = '0;
        if (row_q < ROW_MAX) begin
          row_d = row_q + POS_W'(1);
        end
      end else begin
        col_d = next_col[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tgd_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tgd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tgd_pkg::cell_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output tgd_pkg::cell_t      pop_data_o
);
  import tgd_pkg::*;

  cell_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, wr_d;
  logic [Q_PTR_W-1:0] rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = do_push ? Q_PTR_W'(wr_q + Q_PTR_W'(1)) : wr_q;
    rd_d  = do_pop ? Q_PTR_W'(rd_q + Q_PTR_W'(1)) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tgd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tgd_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_valid_i,
  input  wire tgd_pkg::cell_t             q_data_i,
  output logic                            pop_o,
  input  wire logic [tgd_pkg::COLS_W-1:0] cols_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output tgd_pkg::out_beat_t              out_data_o
);
  import tgd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ID_W-1:0]   quo_q, quo_d;
  logic [COLS_W-1:0] rem_q, rem_d;
  cell_t             cell_q, cell_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;
  logic [COLS_W:0]   trial;
  logic              fits;
  logic              slot_free;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[ID_W-1]};
  assign fits  = (trial >= {1'b0, cols_i});
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o  = 1'b1;
          cell_d = q_data_i;
          quo_d  = q_data_i.index;
          rem_d  = '0;
          cnt_d  = CNT_W'(ID_W - 1);
          // An empty cell has nothing to divide.
          state_d = q_data_i.empty_cell ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        rem_d = fits ? COLS_W'(trial - {1'b0, cols_i}) : trial[COLS_W-1:0];
        quo_d = {quo_q[ID_W-2:0], fits};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Scale to pixels and hand off once the output register is free.
        if (slot_free) begin
          out_d.src_x_px   = SRC_X_W'(32'(rem_q) * 32'(TILE_SIZE));
          out_d.src_y_px   = SRC_Y_W'(64'(quo_q) * 64'(TILE_SIZE));
          out_d.flip_h     = cell_q.flip_h;
          out_d.flip_v     = cell_q.flip_v;
          out_d.dst_x_px   = cell_q.dst_x_px;
          out_d.dst_y_px   = cell_q.dst_y_px;
          out_d.empty_cell = cell_q.empty_cell;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    cell_q <= cell_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/tile_gid_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake             Payload
// in        sink       in_valid_i/in_stall_o   in_beat_t: raw_gid, last_in_layer
// out       source     out_valid_o/out_stall_i out_beat_t: source, destination, flags
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// In the back end a cell is loaded, its tile id goes through a radix-2 restoring
// divide (one quotient bit per cycle), and the result is scaled and handed off.
// An empty cell skips the divide.
// The front accepts up to two beats ahead into its queue while the back divides.
// Reset clears the position counters, the queue and sets both registers to 1.
// A stalled output beat holds in the output register; the back waits on it.

module tile_gid_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire tgd_pkg::in_beat_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output tgd_pkg::out_beat_t                 out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tgd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tgd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tgd_pkg::*;
  `include "tile_gid_decoder_assert.svh"

  logic [COLS_W-1:0] cols_q;
  logic [MAPW_W-1:0] mapw_q;
  logic [COLS_W-1:0] cols_eff;
  logic [MAPW_W-1:0] mapw_eff;
  logic              push, q_full, q_valid, pop;
  cell_t             push_data, pop_data;
  logic [DST_W-1:0]  cols_px;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_W'(1);
      mapw_q <= MAPW_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TILESET_COLUMNS: cols_q <= cfg_data_i[COLS_W-1:0];
        REG_MAP_WIDTH:       mapw_q <= cfg_data_i[MAPW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp register values into their meaningful ranges.
  always_comb begin
    cols_eff = cols_q;
    if (cols_q == '0) begin
      cols_eff = COLS_W'(1);
    end else if (cols_q > COLS_MAX) begin
      cols_eff = COLS_MAX;
    end
    mapw_eff = mapw_q;
    if (mapw_q == '0) begin
      mapw_eff = MAPW_W'(1);
    end else if (mapw_q > MAPW_MAX) begin
      mapw_eff = MAPW_MAX;
    end
  end

  tgd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .map_width_i (mapw_eff),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  tgd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  tgd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .cols_i      (cols_eff),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Width of one tileset row in pixels, for checking the source column.
  assign cols_px = DST_W'(32'(cols_eff) * 32'(TILE_SIZE));

  `TGD_ASSERT_IMP(a_empty_no_src, clk_i, rst_ni, out_valid_o && out_data_o.empty_cell, out_data_o.src_x_px == '0 && out_data_o.src_y_px == '0 && !out_data_o.flip_h && !out_data_o.flip_v)
  `TGD_ASSERT_IMP(a_src_x_in_row, clk_i, rst_ni, out_valid_o, DST_W'(out_data_o.src_x_px) < cols_px)
  `TGD_ASSERT_NXT(a_full_stalls, clk_i, rst_ni, in_valid_i && !in_stall_o && q_full == 1'b0 && q_valid && !pop, in_stall_o)

endmodule

`default_nettype wire
